### design/psp_pkg.sv
// Shared types and constants for the pedestal subtraction / peak finder.
// Used by psp_arith and the top level pedestal_subtract_peak_find_unit.
// No dependencies.
package psp_pkg;

    // Default geometry of the sample frame
    localparam int DEF_NUM_CHIPS         = 4;
    localparam int DEF_CHANNELS_PER_CHIP = 68;
    localparam int DEF_NUM_BUCKETS       = 512;

    // Fixed field widths
    localparam int CMD_W    = 3;
    localparam int CHIP_W   = 2;
    localparam int CHAN_W   = 7;
    localparam int BUCKET_W = 9;
    localparam int SAMPLE_W = 12;
    localparam int VALUE_W  = 16;
    localparam int WS_W     = 9;
    localparam int WL_W     = 10;
    localparam int FRAC_W   = 4;

    // Window sum and the 22.4 dividend
    localparam int SUM_W = SAMPLE_W + WL_W;
    localparam int DIV_W = SUM_W + FRAC_W;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic REG_WINDOW_START  = 1'b0;
    localparam logic REG_WINDOW_LENGTH = 1'b1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE_RAW = 3'd0;
    localparam logic [CMD_W-1:0] CMD_COMPUTE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_CORR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_RAW  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_PEAK = 3'd4;

    // Operations of the shared arithmetic unit
    typedef enum logic [2:0] {
        AR_NOP,
        AR_CLEAR,
        AR_ACC,
        AR_DIV_LOAD,
        AR_DIV_STEP,
        AR_SUB
    } t_arith_op;

    typedef struct packed {
        logic [VALUE_W-1:0] diff;
        logic               borrow;
    } t_arith_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHAN,
        ST_ADDR,
        ST_MEM,
        ST_RESULT,
        ST_C_INIT,
        ST_C_CHAN,
        ST_C_SUM,
        ST_C_SUMEND,
        ST_C_DIVLD,
        ST_C_DIV,
        ST_C_PASS_INIT,
        ST_C_PASS,
        ST_C_DRAIN1,
        ST_C_DRAIN2,
        ST_C_PEAK
    } t_state;

endpackage

### design/psp_ram.sv
// Single-port synchronous RAM with registered read data.
// Used for the raw, corrected and peak stores. No package dependency.
module psp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/psp_arith.sv
// Shared add/subtract unit: window accumulation, restoring division and
// pedestal minus sample subtraction, one operation per cycle.
// Depends on psp_pkg.
module psp_arith import psp_pkg::*; (
    input  logic               i_clk,
    input  t_arith_op          i_op,
    input  logic [VALUE_W-1:0] i_operand,
    input  logic [WL_W-1:0]    i_divisor,
    output t_arith_res         o_res
);

    logic [SUM_W-1:0]   r_acc;
    logic [DIV_W-1:0]   r_quo;
    logic [WL_W-1:0]    r_rem;
    logic [VALUE_W-1:0] r_diff;
    logic               r_borrow;

    logic [SUM_W-1:0] alu_a;
    logic [SUM_W-1:0] alu_b;
    logic             alu_sub;
    logic [SUM_W:0]   alu_sum;
    logic [WL_W:0]    trial;

    assign trial = {r_rem, r_quo[DIV_W-1]};

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (i_op)
            AR_ACC: begin
                alu_a = r_acc;
                alu_b = SUM_W'(i_operand);
            end
            AR_DIV_STEP: begin
                alu_a   = SUM_W'(trial);
                alu_b   = SUM_W'(i_divisor);
                alu_sub = 1'b1;
            end
            AR_SUB: begin
                // pedestal sits in the low quotient bits after division
                alu_a   = SUM_W'(r_quo[VALUE_W-1:0]);
                alu_b   = SUM_W'(i_operand);
                alu_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // carry out set on subtract means no borrow
    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + (SUM_W+1)'(alu_sub);

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            AR_CLEAR: begin
                r_acc <= '0;
            end
            AR_ACC: begin
                r_acc <= alu_sum[SUM_W-1:0];
            end
            AR_DIV_LOAD: begin
                r_quo <= {r_acc, {FRAC_W{1'b0}}};
                r_rem <= '0;
            end
            AR_DIV_STEP: begin
                r_rem <= alu_sum[SUM_W] ? alu_sum[WL_W-1:0] : trial[WL_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], alu_sum[SUM_W]};
            end
            AR_SUB: begin
                r_diff   <= alu_sum[VALUE_W-1:0];
                r_borrow <= ~alu_sum[SUM_W];
            end
            default: begin
            end
        endcase
    end

    assign o_res.diff   = r_diff;
    assign o_res.borrow = r_borrow;

endmodule

### design/pedestal_subtract_peak_find_unit.sv
// Pedestal subtraction and peak finder: top level with sequencer, stores
// and configuration registers. Depends on psp_pkg, psp_ram, psp_arith.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// Command 0 writes a raw sample, 3 reads it back, 1 computes pedestals and
// corrected values for the whole frame, 2 reads a corrected value and
// 4 the peak bucket of a channel. Every item yields one result, shown for
// a single cycle with o_done high; the receiver cannot stall it.
// Writes, reads and unknown commands show their result as busy falls. A
// compute walks every channel through the single-ported raw and corrected
// stores and the shared add/subtract unit: per channel a setup, a sum over
// n buckets and its closing state, a division load, 26 division steps, a
// pass setup, a pass over every bucket, the drain states and a peak write
// (n is the clipped window length; with n = 0 the sum, its closing state
// and the division steps are skipped). The window registers sit on the APB
// port at byte addresses 0 and 4; the user must write them only while busy
// is low, which the block does not enforce. Reset clears the sequencer, the
// computed flag and the window registers (start 0, length 1); the sample
// stores hold no reset value and need no clearing pass.
module pedestal_subtract_peak_find_unit import psp_pkg::*; #(
    parameter int NUM_CHIPS         = DEF_NUM_CHIPS,
    parameter int CHANNELS_PER_CHIP = DEF_CHANNELS_PER_CHIP,
    parameter int NUM_BUCKETS       = DEF_NUM_BUCKETS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [CHIP_W-1:0]     i_chip_index,
    input  logic [CHAN_W-1:0]     i_channel_index,
    input  logic [BUCKET_W-1:0]   i_bucket_index,
    input  logic [SAMPLE_W-1:0]   i_raw_sample,
    // result channel
    output logic                  o_done,
    output logic [VALUE_W-1:0]    o_read_value,
    output logic [BUCKET_W-1:0]   o_peak_bucket,
    output logic                  o_computed,
    output logic                  o_error,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NUM_CH = NUM_CHIPS * CHANNELS_PER_CHIP;
    localparam int CH_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
    localparam int BK_W   = $clog2(NUM_BUCKETS);
    localparam int DEPTH  = NUM_CH * NUM_BUCKETS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = (BK_W > WL_W) ? BK_W : WL_W;

    t_state r_state, n_state;

    // latched item
    logic [CMD_W-1:0]    r_cmd;
    logic [CHIP_W-1:0]   r_chip;
    logic [CHAN_W-1:0]   r_chan;
    logic [BUCKET_W-1:0] r_bucket;
    logic [SAMPLE_W-1:0] r_sample;

    logic [CH_W-1:0]   r_chanidx;
    logic              r_chan_ok;
    logic              r_addr_ok;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_base;
    logic [CH_W-1:0]   r_ch;
    logic [CNT_W-1:0]  r_cnt;
    logic [WL_W-1:0]   r_n;

    // corrected value pipeline
    logic              r_s1_valid;
    logic [BK_W-1:0]   r_s1_bk;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s2_valid;
    logic [BK_W-1:0]   r_s2_bk;
    logic [ADDR_W-1:0] r_s2_addr;
    logic              r_s2_zero;

    logic [VALUE_W-1:0] r_max;
    logic [BK_W-1:0]    r_peak;

    logic            r_computed;
    logic [WS_W-1:0] r_wstart;
    logic [WL_W-1:0] r_wlen;

    logic                r_done;
    logic [VALUE_W-1:0]  r_read_value;
    logic [BUCKET_W-1:0] r_peak_out;
    logic                r_out_computed;
    logic                r_error;

    // control from the output decoder
    t_arith_op          arith_op;
    logic [VALUE_W-1:0] arith_operand;
    t_arith_res         arith_res;
    logic               issue;
    logic               pass_phase;
    logic               raw_we;
    logic               peak_we;
    logic [CH_W-1:0]    peak_addr;

    logic [SAMPLE_W-1:0] raw_rdata;
    logic [VALUE_W-1:0]  corr_rdata;
    logic [BK_W-1:0]     peak_rdata;
    logic [ADDR_W-1:0]   corr_addr;
    logic [VALUE_W-1:0]  corr;

    logic             cfg_write;
    logic [CNT_W:0]   buckets_left;
    logic [WL_W-1:0]  win_n;
    logic             last_ch;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wstart <= '0;
            r_wlen   <= WL_W'(1);
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_WINDOW_START:  r_wstart <= pwdata[WS_W-1:0];
                REG_WINDOW_LENGTH: r_wlen   <= pwdata[WL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WINDOW_START:  prdata = APB_DATA_W'(r_wstart);
            REG_WINDOW_LENGTH: prdata = APB_DATA_W'(r_wlen);
            default:           prdata = '0;
        endcase
    end

    // clip the window at the end of the channel
    assign buckets_left = (CNT_W+1)'(NUM_BUCKETS) - (CNT_W+1)'(r_wstart);

    always_comb begin
        win_n = '0;
        if ((CNT_W+1)'(r_wstart) < (CNT_W+1)'(NUM_BUCKETS)) begin
            if ((CNT_W+1)'(r_wlen) > buckets_left) begin
                win_n = WL_W'(buckets_left);
            end else begin
                win_n = r_wlen;
            end
        end
    end

    assign last_ch = (r_ch == CH_W'(NUM_CH - 1));

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_command == CMD_COMPUTE) ? ST_C_INIT : ST_CHAN;
                end
            end
            ST_CHAN:   n_state = ST_ADDR;
            ST_ADDR:   n_state = ST_MEM;
            ST_MEM:    n_state = ST_RESULT;
            ST_RESULT: n_state = ST_IDLE;
            ST_C_INIT: n_state = ST_C_CHAN;
            ST_C_CHAN: n_state = (r_n == '0) ? ST_C_DIVLD : ST_C_SUM;
            ST_C_SUM: begin
                if (r_cnt == CNT_W'(r_n) - CNT_W'(1)) begin
                    n_state = ST_C_SUMEND;
                end
            end
            ST_C_SUMEND: n_state = ST_C_DIVLD;
            ST_C_DIVLD:  n_state = (r_n == '0) ? ST_C_PASS_INIT : ST_C_DIV;
            ST_C_DIV: begin
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = ST_C_PASS_INIT;
                end
            end
            ST_C_PASS_INIT: n_state = ST_C_PASS;
            ST_C_PASS: begin
                if (r_cnt == CNT_W'(NUM_BUCKETS - 1)) begin
                    n_state = ST_C_DRAIN1;
                end
            end
            ST_C_DRAIN1: n_state = ST_C_DRAIN2;
            ST_C_DRAIN2: n_state = ST_C_PEAK;
            ST_C_PEAK:   n_state = last_ch ? ST_RESULT : ST_C_CHAN;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        arith_op   = AR_NOP;
        issue      = 1'b0;
        pass_phase = 1'b0;
        raw_we     = 1'b0;
        peak_we    = 1'b0;
        unique case (r_state)
            ST_MEM: begin
                raw_we = (r_cmd == CMD_WRITE_RAW) && r_addr_ok;
            end
            ST_C_CHAN: begin
                arith_op = AR_CLEAR;
            end
            ST_C_SUM: begin
                issue    = 1'b1;
                arith_op = r_s1_valid ? AR_ACC : AR_NOP;
            end
            ST_C_SUMEND: begin
                arith_op = r_s1_valid ? AR_ACC : AR_NOP;
            end
            ST_C_DIVLD: begin
                arith_op = AR_DIV_LOAD;
            end
            ST_C_DIV: begin
                arith_op = AR_DIV_STEP;
            end
            ST_C_PASS: begin
                issue      = 1'b1;
                pass_phase = 1'b1;
                arith_op   = r_s1_valid ? AR_SUB : AR_NOP;
            end
            ST_C_DRAIN1: begin
                pass_phase = 1'b1;
                arith_op   = r_s1_valid ? AR_SUB : AR_NOP;
            end
            ST_C_PEAK: begin
                peak_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_computed <= 1'b0;
            r_done     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_done     <= (r_state == ST_RESULT);
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid && pass_phase;
            if (r_state == ST_C_PEAK && last_ch) begin
                r_computed <= 1'b1;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_cmd    <= i_command;
                    r_chip   <= i_chip_index;
                    r_chan   <= i_channel_index;
                    r_bucket <= i_bucket_index;
                    r_sample <= i_raw_sample;
                end
            end
            ST_CHAN: begin
                r_chan_ok <= (int'(r_chip) < NUM_CHIPS)
                          && (int'(r_chan) < CHANNELS_PER_CHIP);
                r_addr_ok <= (int'(r_chip) < NUM_CHIPS)
                          && (int'(r_chan) < CHANNELS_PER_CHIP)
                          && (int'(r_bucket) < NUM_BUCKETS);
                r_chanidx <= CH_W'(int'(r_chip) * CHANNELS_PER_CHIP + int'(r_chan));
            end
            ST_ADDR: begin
                r_addr <= ADDR_W'(r_chanidx) * ADDR_W'(NUM_BUCKETS)
                        + ADDR_W'(r_bucket);
            end
            ST_C_INIT: begin
                r_n    <= win_n;
                r_ch   <= '0;
                r_base <= '0;
            end
            ST_C_CHAN: begin
                r_addr <= r_base + ADDR_W'(r_wstart);
                r_cnt  <= '0;
            end
            ST_C_SUM, ST_C_PASS: begin
                r_addr <= r_addr + ADDR_W'(1);
                r_cnt  <= r_cnt + CNT_W'(1);
            end
            ST_C_DIVLD: begin
                r_cnt <= '0;
            end
            ST_C_DIV: begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ST_C_PASS_INIT: begin
                r_addr <= r_base;
                r_cnt  <= '0;
            end
            ST_C_PEAK: begin
                if (!last_ch) begin
                    r_ch   <= r_ch + CH_W'(1);
                    r_base <= r_base + ADDR_W'(NUM_BUCKETS);
                end
            end
            default: begin
            end
        endcase
    end

    // stage 1: raw sample back from the store; stage 2: corrected value
    always_ff @(posedge i_clk) begin
        r_s1_bk   <= r_cnt[BK_W-1:0];
        r_s1_addr <= r_addr;
        r_s2_bk   <= r_s1_bk;
        r_s2_addr <= r_s1_addr;
        r_s2_zero <= (raw_rdata == '0);
    end

    assign corr = (r_s2_zero || arith_res.borrow) ? '0 : arith_res.diff;

    // running maximum; bucket 0 seeds it, the last bucket never wins
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            if (r_s2_bk == '0) begin
                r_max  <= corr;
                r_peak <= '0;
            end else if (r_s2_bk != BK_W'(NUM_BUCKETS - 1) && corr > r_max) begin
                r_max  <= corr;
                r_peak <= r_s2_bk;
            end
        end
    end

    // ---------------- result ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESULT) begin
            r_read_value   <= '0;
            r_peak_out     <= '0;
            r_error        <= 1'b0;
            r_out_computed <= r_computed;
            unique case (r_cmd)
                CMD_READ_CORR: begin
                    r_error <= ~r_computed;
                    if (r_computed && r_addr_ok) begin
                        r_read_value <= corr_rdata;
                    end
                end
                CMD_READ_RAW: begin
                    if (r_addr_ok) begin
                        r_read_value <= VALUE_W'(raw_rdata);
                    end
                end
                CMD_READ_PEAK: begin
                    r_error <= ~r_computed;
                    if (r_computed && r_chan_ok) begin
                        r_peak_out <= BUCKET_W'(peak_rdata);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_read_value  = r_read_value;
    assign o_peak_bucket = r_peak_out;
    assign o_computed    = r_out_computed;
    assign o_error       = r_error;

    // ---------------- arithmetic unit and stores ----------------
    assign arith_operand = pass_phase ? {raw_rdata, {FRAC_W{1'b0}}}
                                      : VALUE_W'(raw_rdata);

    psp_arith u_arith (
        .i_clk     (i_clk),
        .i_op      (arith_op),
        .i_operand (arith_operand),
        .i_divisor (r_n),
        .o_res     (arith_res)
    );

    psp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_raw_store (
        .i_clk   (i_clk),
        .i_we    (raw_we),
        .i_addr  (r_addr),
        .i_wdata (r_sample),
        .o_rdata (raw_rdata)
    );

    assign corr_addr = r_s2_valid ? r_s2_addr : r_addr;

    psp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_corr_store (
        .i_clk   (i_clk),
        .i_we    (r_s2_valid),
        .i_addr  (corr_addr),
        .i_wdata (corr),
        .o_rdata (corr_rdata)
    );

    assign peak_addr = peak_we ? r_ch : r_chanidx;

    psp_ram #(
        .WIDTH (BK_W),
        .DEPTH (NUM_CH)
    ) u_peak_store (
        .i_clk   (i_clk),
        .i_we    (peak_we),
        .i_addr  (peak_addr),
        .i_wdata (r_peak),
        .o_rdata (peak_rdata)
    );

endmodule

### tb/sv/pedestal_subtract_peak_find_unit_tb.sv
// Self-checking testbench for pedestal_subtract_peak_find_unit: fills the
// sample frame, runs pedestal passes under several windows, checks every readout.
// Depends on psp_pkg and the unit's RTL only.
module pedestal_subtract_peak_find_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psp_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 20_000_000;

    localparam int N_CHIPS         = DEF_NUM_CHIPS;
    localparam int N_CHAN_PER_CHIP = DEF_CHANNELS_PER_CHIP;
    localparam int N_BUCKETS       = DEF_NUM_BUCKETS;
    localparam int N_CHANNELS      = N_CHIPS * N_CHAN_PER_CHIP;
    localparam int FRAME_WORDS     = N_CHANNELS * N_BUCKETS;

    localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
    localparam int CHIP_LAST       = N_CHIPS - 1;
    localparam int CHAN_LAST       = N_CHAN_PER_CHIP - 1;
    localparam int CHAN_FIELD_MAX  = (1 << CHAN_W) - 1;
    localparam int BUCKET_LAST     = N_BUCKETS - 1;

    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [CHIP_W-1:0]   chip;
        logic [CHAN_W-1:0]   chan;
        logic [BUCKET_W-1:0] bucket;
        logic [SAMPLE_W-1:0] sample;
    } t_frame_cmd;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [BUCKET_W-1:0] peak;
        logic                computed;
        logic                error;
    } t_readout;

    typedef enum int {IDLE_LIGHT, IDLE_HEAVY} t_idle_mode;
    typedef enum int {SHAPE_FLAT, SHAPE_EDGE_DIPS, SHAPE_ALTERNATE, SHAPE_PULSE} t_frame_shape;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [CMD_W-1:0]      i_command       = '0;
    logic [CHIP_W-1:0]     i_chip_index    = '0;
    logic [CHAN_W-1:0]     i_channel_index = '0;
    logic [BUCKET_W-1:0]   i_bucket_index  = '0;
    logic [SAMPLE_W-1:0]   i_raw_sample    = '0;
    logic                  o_done;
    logic [VALUE_W-1:0]    o_read_value;
    logic [BUCKET_W-1:0]   o_peak_bucket;
    logic                  o_computed;
    logic                  o_error;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [PADDR_W-1:0]    paddr           = '0;
    logic [APB_DATA_W-1:0] pwdata          = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pedestal_subtract_peak_find_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_chip_index    (i_chip_index),
        .i_channel_index (i_channel_index),
        .i_bucket_index  (i_bucket_index),
        .i_raw_sample    (i_raw_sample),
        .o_done          (o_done),
        .o_read_value    (o_read_value),
        .o_peak_bucket   (o_peak_bucket),
        .o_computed      (o_computed),
        .o_error         (o_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Predicted contents of the unit
    bit [SAMPLE_W-1:0] frame_raw  [FRAME_WORDS];
    bit [VALUE_W-1:0]  frame_corr [FRAME_WORDS];
    bit [BUCKET_W-1:0] chan_peak  [N_CHANNELS];
    bit                ped_done   = 1'b0;
    bit [WS_W-1:0]     win_start  = '0;
    bit [WL_W-1:0]     win_len    = WL_W'(1);

    t_frame_cmd cmd_queue[$];
    t_readout   expected_reads[$];
    t_frame_cmd in_flight;
    t_readout   due;
    t_idle_mode idle_mode   = IDLE_HEAVY;
    int         gap_left    = 0;
    int         mismatches  = 0;
    int         cycle_count = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h",
                 cycle_count, what, got, want);
        mismatches++;
    endtask

    // Average the window into a 12.4 pedestal, subtract, and track the peak per channel
    function automatic void pedestal_pass();
        int unsigned       n, sum, ped, base, top;
        bit [VALUE_W-1:0]  raw16, corr;
        n = 0;
        if (win_start < N_BUCKETS) begin
            n = win_len;
            if (n > N_BUCKETS - win_start)
                n = N_BUCKETS - win_start;
        end
        for (int ch = 0; ch < N_CHANNELS; ch++) begin
            base = ch * N_BUCKETS;
            sum  = 0;
            for (int b = 0; b < n; b++)
                sum += frame_raw[base + win_start + b];
            ped = (n != 0) ? (sum << FRAC_W) / n : 0;
            top = 0;
            for (int b = 0; b < N_BUCKETS; b++) begin
                raw16 = {frame_raw[base + b], {FRAC_W{1'b0}}};
                if (raw16 == 0 || ped < raw16)
                    corr = '0;
                else
                    corr = VALUE_W'(ped - raw16);
                frame_corr[base + b] = corr;
                // bucket 0 is the default, the last bucket never wins; ties keep the earlier bucket
                if (b > 0 && b < N_BUCKETS - 1 && corr > frame_corr[base + top])
                    top = b;
            end
            chan_peak[ch] = BUCKET_W'(top);
        end
        ped_done = 1'b1;
    endfunction

    function automatic void predict_readout(t_frame_cmd it);
        t_readout    r;
        bit          chan_ok, addr_ok;
        int unsigned chan_idx, addr;
        r        = '0;
        chan_ok  = it.chip < N_CHIPS && it.chan < N_CHAN_PER_CHIP;
        addr_ok  = chan_ok && it.bucket < N_BUCKETS;
        chan_idx = it.chip * N_CHAN_PER_CHIP + it.chan;
        addr     = chan_idx * N_BUCKETS + it.bucket;
        case (it.cmd)
            CMD_WRITE_RAW: if (addr_ok) frame_raw[addr] = it.sample;
            CMD_COMPUTE:   pedestal_pass();
            CMD_READ_CORR: begin
                if (!ped_done)
                    r.error = 1'b1;
                else if (addr_ok)
                    r.value = frame_corr[addr];
            end
            CMD_READ_RAW:  if (addr_ok) r.value = VALUE_W'(frame_raw[addr]);
            CMD_READ_PEAK: begin
                if (!ped_done)
                    r.error = 1'b1;
                else if (chan_ok)
                    r.peak = chan_peak[chan_idx];
            end
            default: ;
        endcase
        r.computed = ped_done;
        expected_reads.push_back(r);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == IDLE_LIGHT) begin
            if (r < 92)
                return 0;
            if (r < 99)
                return $urandom_range(1, 4);
            return $urandom_range(5, 20);
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 6);
        return $urandom_range(7, 40);
    endfunction

    function automatic void queue_cmd(logic [CMD_W-1:0] cmd, int chip, int chan,
                                      int bucket, int sample);
        t_frame_cmd it;
        it.cmd    = cmd;
        it.chip   = CHIP_W'(chip);
        it.chan   = CHAN_W'(chan);
        it.bucket = BUCKET_W'(bucket);
        it.sample = SAMPLE_W'(sample);
        cmd_queue.push_back(it);
    endfunction

    function automatic void queue_any(logic [CMD_W-1:0] cmd);
        queue_cmd(cmd, $urandom_range(0, CHIP_LAST), $urandom_range(0, CHAN_FIELD_MAX),
                  $urandom_range(0, BUCKET_LAST), $urandom_range(0, SAMPLE_MAX));
    endfunction

    // Mostly in-range traffic, with write/readback pairs and some stray channels
    function automatic void queue_random_traffic(int count);
        int made, pick, chip, chan, bkt, smp;
        made = 0;
        while (made < count) begin
            chip = $urandom_range(0, CHIP_LAST);
            chan = ($urandom_range(0, 19) == 0) ? $urandom_range(N_CHAN_PER_CHIP, CHAN_FIELD_MAX)
                                                : $urandom_range(0, CHAN_LAST);
            bkt  = $urandom_range(0, BUCKET_LAST);
            smp  = $urandom_range(0, SAMPLE_MAX);
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                queue_cmd(CMD_WRITE_RAW, chip, chan, bkt, smp);
                queue_cmd(CMD_READ_RAW, chip, chan, bkt, $urandom_range(0, SAMPLE_MAX));
                made += 2;
            end else if (pick < 35) begin
                queue_cmd(CMD_WRITE_RAW, chip, chan, bkt, smp);
                made++;
            end else if (pick < 55) begin
                queue_cmd(CMD_READ_CORR, chip, chan, bkt, smp);
                made++;
            end else if (pick < 70) begin
                queue_cmd(CMD_READ_RAW, chip, chan, bkt, smp);
                made++;
            end else if (pick < 88) begin
                queue_cmd(CMD_READ_PEAK, chip, chan, bkt, smp);
                made++;
            end else if (pick < 94) begin
                // corrected value stays from the last pass after a new write
                queue_cmd(CMD_WRITE_RAW, chip, chan, bkt, smp);
                queue_cmd(CMD_READ_CORR, chip, chan, bkt, $urandom_range(0, SAMPLE_MAX));
                made += 2;
            end else begin
                queue_cmd(CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)),
                          chip, chan, bkt, smp);
                made++;
            end
        end
    endfunction

    task automatic apb_cycle(input bit wr, input logic idx, input logic [APB_DATA_W-1:0] wdata,
                             output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_window_reg(input logic idx);
        logic [APB_DATA_W-1:0] rd;
        apb_cycle(1'b0, idx, '0, rd);
        if (idx == REG_WINDOW_START) begin
            if (rd !== APB_DATA_W'(win_start))
                report_mismatch("window_start readback", rd, win_start);
        end else if (rd !== APB_DATA_W'(win_len)) begin
            report_mismatch("window_length readback", rd, win_len);
        end
    endtask

    task automatic set_window_reg(input logic idx, input int unsigned value);
        logic [APB_DATA_W-1:0] ignored;
        apb_cycle(1'b1, idx, value, ignored);
        if (idx == REG_WINDOW_START)
            win_start = WS_W'(value);
        else
            win_len = WL_W'(value);
        check_window_reg(idx);
    endtask

    // Hold until every queued item is taken and every readout is back
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (cmd_queue.size() != 0 || start || busy || expected_reads.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Command driver: hold an item while busy, then insert a random gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (!(start && busy)) begin
            if (start)
                predict_readout(in_flight);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                in_flight = cmd_queue.pop_front();
                i_command       <= in_flight.cmd;
                i_chip_index    <= in_flight.chip;
                i_channel_index <= in_flight.chan;
                i_bucket_index  <= in_flight.bucket;
                i_raw_sample    <= in_flight.sample;
                start           <= 1'b1;
                gap_left        <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Readout monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_reads.size() == 0) begin
                report_mismatch("readout with no item pending", o_read_value, 0);
            end else begin
                due = expected_reads.pop_front();
                if (o_read_value !== due.value)
                    report_mismatch("read_value", o_read_value, due.value);
                if (o_peak_bucket !== due.peak)
                    report_mismatch("peak_bucket", o_peak_bucket, due.peak);
                if (o_computed !== due.computed)
                    report_mismatch("computed", o_computed, due.computed);
                if (o_error !== due.error)
                    report_mismatch("error", o_error, due.error);
            end
        end
    end

    initial begin
        int           level, dip_at, dip, s, pick;
        t_frame_shape shape;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_window_reg(REG_WINDOW_START);
        check_window_reg(REG_WINDOW_LENGTH);

        // Before any pass: error reads, unknown codes, corner writes and readback
        idle_mode = IDLE_HEAVY;
        queue_cmd(CMD_READ_CORR, 0, 0, 0, 0);
        queue_cmd(CMD_READ_PEAK, CHIP_LAST, CHAN_LAST, BUCKET_LAST, SAMPLE_MAX);
        queue_cmd(CMD_READ_CORR, CHIP_LAST, CHAN_FIELD_MAX, BUCKET_LAST, 0);
        queue_cmd(CMD_READ_PEAK, 1, N_CHAN_PER_CHIP, 0, 0);
        for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++)
            queue_any(CMD_W'(c));
        queue_cmd(CMD_WRITE_RAW, 0, 0, 0, 0);
        queue_cmd(CMD_WRITE_RAW, CHIP_LAST, CHAN_LAST, BUCKET_LAST, SAMPLE_MAX);
        queue_cmd(CMD_WRITE_RAW, CHIP_LAST, CHAN_FIELD_MAX, BUCKET_LAST, SAMPLE_MAX);
        queue_cmd(CMD_WRITE_RAW, 2, N_CHAN_PER_CHIP, 0, 12'hAAA);
        queue_cmd(CMD_WRITE_RAW, 1, 33, 255, 12'h555);
        queue_cmd(CMD_READ_RAW, 0, 0, 0, SAMPLE_MAX);
        queue_cmd(CMD_READ_RAW, CHIP_LAST, CHAN_LAST, BUCKET_LAST, 0);
        queue_cmd(CMD_READ_RAW, CHIP_LAST, CHAN_FIELD_MAX, BUCKET_LAST, 0);
        queue_cmd(CMD_READ_RAW, 1, 33, 255, 0);
        queue_cmd(CMD_WRITE_RAW, 1, 33, 255, 12'hAAA);
        queue_cmd(CMD_READ_RAW, 1, 33, 255, 12'h555);
        wait_idle();

        // Fill the whole frame so every pass reads written samples only
        idle_mode = IDLE_LIGHT;
        for (int ch = 0; ch < N_CHANNELS; ch++) begin
            level  = $urandom_range(40, 4000);
            dip_at = $urandom_range(0, BUCKET_LAST);
            dip    = $urandom_range(0, level);
            pick   = $urandom_range(0, 19);
            shape  = (pick < 2) ? SHAPE_FLAT : (pick < 4) ? SHAPE_EDGE_DIPS :
                     (pick < 5) ? SHAPE_ALTERNATE : SHAPE_PULSE;
            for (int b = 0; b < N_BUCKETS; b++) begin
                case (shape)
                    SHAPE_FLAT:      s = level;
                    // deepest dips sit on the edge buckets: bucket 0 only seeds the peak, the last never wins
                    SHAPE_EDGE_DIPS: s = (b == 0) ? level / 2 :
                                         (b == BUCKET_LAST) ? level / 4 : level;
                    SHAPE_ALTERNATE: s = b[0] ? SAMPLE_MAX : 0;
                    default: begin
                        s = level + int'($urandom_range(0, 12)) - 6;
                        if (b >= dip_at && b < dip_at + 8)
                            s -= dip;
                        if ($urandom_range(0, 63) == 0)
                            s = 0;
                        else if ($urandom_range(0, 99) == 0)
                            s = SAMPLE_MAX;
                    end
                endcase
                if (s < 0)
                    s = 0;
                if (s > SAMPLE_MAX)
                    s = SAMPLE_MAX;
                queue_cmd(CMD_WRITE_RAW, ch / N_CHAN_PER_CHIP, ch % N_CHAN_PER_CHIP, b, s);
            end
        end
        wait_idle();

        // Window at the last bucket, length all ones: clipped to one bucket
        set_window_reg(REG_WINDOW_START, (1 << WS_W) - 1);
        set_window_reg(REG_WINDOW_LENGTH, (1 << WL_W) - 1);
        idle_mode = IDLE_HEAVY;
        queue_any(CMD_COMPUTE);
        queue_cmd(CMD_READ_CORR, 0, 0, 0, 0);
        queue_cmd(CMD_READ_CORR, CHIP_LAST, CHAN_LAST, BUCKET_LAST, 0);
        queue_cmd(CMD_READ_CORR, 0, 0, BUCKET_LAST, 0);
        queue_cmd(CMD_READ_CORR, CHIP_LAST, CHAN_FIELD_MAX, 0, 0);
        for (int c = 0; c <= CHIP_LAST; c++) begin
            queue_cmd(CMD_READ_PEAK, c, 0, 0, 0);
            queue_cmd(CMD_READ_PEAK, c, CHAN_LAST, BUCKET_LAST, 0);
        end
        queue_cmd(CMD_READ_PEAK, 2, CHAN_FIELD_MAX, 0, 0);
        queue_cmd(CMD_READ_RAW, 0, N_CHAN_PER_CHIP, 0, 0);
        for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++)
            queue_any(CMD_W'(c));
        queue_random_traffic(600);
        wait_idle();

        // Empty window: zero pedestal, every corrected value zero
        set_window_reg(REG_WINDOW_LENGTH, 0);
        set_window_reg(REG_WINDOW_START, 0);
        queue_any(CMD_COMPUTE);
        queue_random_traffic(600);
        wait_idle();

        // Full-length readback, then a random short window for the last pass
        set_window_reg(REG_WINDOW_LENGTH, N_BUCKETS);
        set_window_reg(REG_WINDOW_START, $urandom_range(0, 480));
        set_window_reg(REG_WINDOW_LENGTH, $urandom_range(2, 48));
        queue_any(CMD_COMPUTE);
        queue_random_traffic(700);
        wait_idle();

        if (mismatches == 0 && expected_reads.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
